// ===== design/ccc_pkg.sv =====
// Shared constants, field widths and class codes for the circle cell coverage block.
package ccc_pkg;

  // Field and register widths
  localparam int COORD_W    = 10;
  localparam int RADIUS_W   = 12;
  localparam int CLASS_W    = 2;
  localparam int COV_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // Defaults for the top-level parameters and fixed lattice size
  localparam int SUBDIV_DEF = 5;
  localparam int GRID_WIDTH = 1024;

  // Half a cell in tenths, and one cell squared in tenths squared
  localparam int HALF_CELL_TENTHS = 5;
  localparam int CELL_TENTHS_SQ   = 100;

  // Largest count the coverage field holds
  localparam int COV_MAX = 31;

  // Cell class codes
  localparam logic [CLASS_W-1:0] CLASS_FLUID     = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_SOLID     = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_INTERFACE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd2;

  // Register reset values
  localparam logic [COORD_W-1:0]  CENTER_X_RST = 10'd26;
  localparam logic [COORD_W-1:0]  CENTER_Y_RST = 10'd26;
  localparam logic [RADIUS_W-1:0] RADIUS_RST   = 12'd100;

endpackage

// ===== design/circle_cell_coverage.sv =====
// Circle cell coverage classifier: pipelined fluid/solid/interface test with sub-point count.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one lattice cell (cell_x, cell_y) per
//   transaction. The output channel (out_valid/out_ready) returns one transaction per cell:
//   cell_class (fluid, solid or interface) and covered_subsamples, the solid fraction in
//   SUBDIV*SUBDIV parts (0 for fluid, full for solid, counted sub-points for interface).
//   The circle is set through cfg_we/cfg_index/cfg_data: center column, center row and
//   radius in tenths of a cell. Write it only while no transaction is in flight.
//   Pipeline: five register stages (offsets, squares, compares, row counts, final sum);
//   the result sits in the output register. Throughput: one cell per cycle; every stage is
//   a short piece of logic, so a new cell enters at every clock while the receiver keeps up.
//   When the receiver stalls with a result waiting, the whole pipeline holds and in_ready
//   drops; it resumes in the cycle the waiting result is taken, so no transaction is lost.
//   Reset (rst, synchronous) empties the pipeline and loads the default circle:
//   center (26, 26), radius 10.0 cells.
module circle_cell_coverage #(
  parameter int SUBDIV = ccc_pkg::SUBDIV_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [ccc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ccc_pkg::CFG_DATA_W-1:0]    cfg_data,
  // cell input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ccc_pkg::COORD_W-1:0]       cell_x,
  input  logic [ccc_pkg::COORD_W-1:0]       cell_y,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ccc_pkg::CLASS_W-1:0]       cell_class,
  output logic [ccc_pkg::COV_W-1:0]         covered_subsamples
);
  import ccc_pkg::*;

  // Sub-point arithmetic works in units of 1/(20*SUBDIV) cell, so every offset is whole.
  localparam int SCALE    = 20 * SUBDIV;
  localparam int OFF_MAX  = 10 * (SUBDIV - 1);
  localparam int PX_MAX   = SCALE * ((1 << COORD_W) - 1) + OFF_MAX;
  localparam int PX_W     = $clog2(PX_MAX + 1) + 1;
  localparam int PX2_W    = 2 * (PX_W - 1);
  localparam int SUM_W    = PX2_W + 1;
  localparam int RAD_MAX  = 2 * SUBDIV * ((1 << RADIUS_W) - 1);
  localparam int RAD_W    = $clog2(RAD_MAX + 1);
  localparam int RAD2_W   = 2 * RAD_W;
  localparam int HIT_W    = (SUM_W > RAD2_W) ? SUM_W : RAD2_W;
  // Class tests work in tenths of a cell.
  localparam int DX_W     = COORD_W + 1;
  localparam int DSQ_W    = 2 * COORD_W + 1;
  localparam int D2_W     = DSQ_W + $clog2(CELL_TENTHS_SQ);
  localparam int RING_W   = RADIUS_W + 1;
  localparam int RING2_W  = 2 * RING_W;
  localparam int INNER2_W = 2 * RADIUS_W;
  localparam int CLS_W    = (D2_W > RING2_W) ? D2_W : RING2_W;
  // Sub-point counting
  localparam int NSUB      = SUBDIV * SUBDIV;
  localparam int ROW_W     = $clog2(SUBDIV + 1);
  localparam int CNT_W     = $clog2(NSUB + 1);
  localparam int SAT_W     = (CNT_W > COV_W) ? CNT_W : COV_W;
  localparam int SOLID_COV = (NSUB > COV_MAX) ? COV_MAX : NSUB;

  localparam logic signed [PX_W-1:0] SCALE_S = PX_W'(SCALE);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [COORD_W-1:0]  circle_center_x;
  logic [COORD_W-1:0]  circle_center_y;
  logic [RADIUS_W-1:0] radius_tenths;

  always_ff @(posedge clk) begin
    if (rst) begin
      circle_center_x <= CENTER_X_RST;
      circle_center_y <= CENTER_Y_RST;
      radius_tenths   <= RADIUS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CENTER_X: circle_center_x <= cfg_data[COORD_W-1:0];
        CFG_CENTER_Y: circle_center_y <= cfg_data[COORD_W-1:0];
        CFG_RADIUS:   radius_tenths   <= cfg_data[RADIUS_W-1:0];
        default:      ; // drop writes to unknown indexes
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: every stage advances together unless a result is stuck.
  // ---------------------------------------------------------------------------
  logic advance;
  logic v1, v2, v3, v4;

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: center offsets, sub-point coordinates, radius terms
  // ---------------------------------------------------------------------------
  logic signed [DX_W-1:0] dx_c, dy_c;
  logic                   on_grid_c;
  logic signed [PX_W-1:0] px_c [SUBDIV];
  logic signed [PX_W-1:0] py_c [SUBDIV];

  assign dx_c = $signed({1'b0, cell_x}) - $signed({1'b0, circle_center_x});
  assign dy_c = $signed({1'b0, cell_y}) - $signed({1'b0, circle_center_y});
  assign on_grid_c = ({1'b0, cell_x} < DX_W'(GRID_WIDTH)) &&
                     ({1'b0, cell_y} < DX_W'(GRID_WIDTH));

  always_comb begin
    for (int a = 0; a < SUBDIV; a++) begin
      px_c[a] = PX_W'(dx_c) * SCALE_S + PX_W'(10 * (2 * a + 1 - SUBDIV));
      py_c[a] = PX_W'(dy_c) * SCALE_S + PX_W'(10 * (2 * a + 1 - SUBDIV));
    end
  end

  logic signed [DX_W-1:0] dx1, dy1;
  logic                   on_grid1;
  logic signed [PX_W-1:0] px1 [SUBDIV];
  logic signed [PX_W-1:0] py1 [SUBDIV];
  logic [RING_W-1:0]      rp5_1;
  logic [RADIUS_W-1:0]    rm5_1;
  logic                   big_r1;
  logic [RAD_W-1:0]       rad1;

  always_ff @(posedge clk) begin
    if (advance) begin
      dx1      <= dx_c;
      dy1      <= dy_c;
      on_grid1 <= on_grid_c;
      px1      <= px_c;
      py1      <= py_c;
      rp5_1    <= RING_W'(radius_tenths) + RING_W'(HALF_CELL_TENTHS);
      // wraps for a radius under half a cell; no solid test then
      rm5_1    <= radius_tenths - RADIUS_W'(HALF_CELL_TENTHS);
      big_r1   <= radius_tenths >= RADIUS_W'(HALF_CELL_TENTHS);
      rad1     <= RAD_W'(radius_tenths) * RAD_W'(2 * SUBDIV);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: squares
  // ---------------------------------------------------------------------------
  logic [PX2_W-1:0] px2_c [SUBDIV];
  logic [PX2_W-1:0] py2_c [SUBDIV];

  always_comb begin
    for (int a = 0; a < SUBDIV; a++) begin
      px2_c[a] = PX2_W'(px1[a]) * PX2_W'(px1[a]);
      py2_c[a] = PX2_W'(py1[a]) * PX2_W'(py1[a]);
    end
  end

  logic [DSQ_W-1:0]    dsq2;
  logic                on_grid2;
  logic                big_r2;
  logic [RING2_W-1:0]  outer2;
  logic [INNER2_W-1:0] inner2;
  logic [RAD2_W-1:0]   rad2;
  logic [PX2_W-1:0]    px2 [SUBDIV];
  logic [PX2_W-1:0]    py2 [SUBDIV];

  always_ff @(posedge clk) begin
    if (advance) begin
      dsq2     <= DSQ_W'(dx1) * DSQ_W'(dx1) + DSQ_W'(dy1) * DSQ_W'(dy1);
      on_grid2 <= on_grid1;
      big_r2   <= big_r1;
      outer2   <= rp5_1 * rp5_1;
      inner2   <= rm5_1 * rm5_1;
      rad2     <= rad1 * rad1;
      px2      <= px2_c;
      py2      <= py2_c;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: class compares and sub-point hits
  // ---------------------------------------------------------------------------
  logic [D2_W-1:0]      d2_c;
  logic [CLASS_W-1:0]   cls_c;
  logic [SUBDIV-1:0]    hit_c [SUBDIV];

  assign d2_c = D2_W'(dsq2) * D2_W'(CELL_TENTHS_SQ);

  always_comb begin
    if (!on_grid2 || (CLS_W'(d2_c) > CLS_W'(outer2))) begin
      cls_c = CLASS_FLUID;
    end else if (big_r2 && (CLS_W'(d2_c) < CLS_W'(inner2))) begin
      cls_c = CLASS_SOLID;
    end else begin
      cls_c = CLASS_INTERFACE;
    end
  end

  always_comb begin
    for (int a = 0; a < SUBDIV; a++) begin
      for (int b = 0; b < SUBDIV; b++) begin
        hit_c[a][b] = HIT_W'(SUM_W'(px2[a]) + SUM_W'(py2[b])) <= HIT_W'(rad2);
      end
    end
  end

  logic [CLASS_W-1:0] cls3;
  logic [SUBDIV-1:0]  hit3 [SUBDIV];

  always_ff @(posedge clk) begin
    if (advance) begin
      cls3 <= cls_c;
      hit3 <= hit_c;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: per-row hit counts
  // ---------------------------------------------------------------------------
  logic [ROW_W-1:0] row_cnt_c [SUBDIV];

  always_comb begin
    for (int a = 0; a < SUBDIV; a++) begin
      row_cnt_c[a] = '0;
      for (int b = 0; b < SUBDIV; b++) begin
        row_cnt_c[a] = row_cnt_c[a] + ROW_W'(hit3[a][b]);
      end
    end
  end

  logic [CLASS_W-1:0] cls4;
  logic [ROW_W-1:0]   row_cnt4 [SUBDIV];

  always_ff @(posedge clk) begin
    if (advance) begin
      cls4     <= cls3;
      row_cnt4 <= row_cnt_c;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: total, saturate, pick coverage by class into the output register
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] total_c;
  logic [COV_W-1:0] count_sat_c;
  logic [COV_W-1:0] cov_c;

  always_comb begin
    total_c = '0;
    for (int a = 0; a < SUBDIV; a++) begin
      total_c = total_c + CNT_W'(row_cnt4[a]);
    end
  end

  assign count_sat_c = (SAT_W'(total_c) > SAT_W'(COV_MAX)) ? COV_W'(COV_MAX)
                                                          : COV_W'(total_c);

  always_comb begin
    case (cls4)
      CLASS_FLUID:     cov_c = '0;
      CLASS_SOLID:     cov_c = COV_W'(SOLID_COV);
      CLASS_INTERFACE: cov_c = count_sat_c;
      default:         cov_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cell_class         <= cls4;
      covered_subsamples <= cov_c;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_fluid_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && (cell_class == CLASS_FLUID) |-> covered_subsamples == '0)
    else $error("fluid cell reported nonzero coverage");

  a_solid_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && (cell_class == CLASS_SOLID) |-> covered_subsamples == COV_W'(SOLID_COV))
    else $error("solid cell reported partial coverage");

  a_class_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cell_class == CLASS_FLUID) || (cell_class == CLASS_SOLID) ||
                  (cell_class == CLASS_INTERFACE))
    else $error("undefined cell class on output");

  a_iface_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && (cell_class == CLASS_INTERFACE) |->
      covered_subsamples <= COV_W'(SOLID_COV))
    else $error("interface count exceeds sub-point total");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v1)
    else $error("accepted cell did not enter the pipeline");

endmodule
